// ----- design/tcpm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcpm_pkg;

  // ring size, derived address width, index and data widths
  localparam int unsigned RING_DEGREE = 509;
  localparam int unsigned AW = $clog2(RING_DEGREE);
  localparam int unsigned IDX_W = 9;
  localparam int unsigned DW = 16;

  // command codes
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_RUN = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // ternary codes
  localparam logic [1:0] CODE_PLUS = 2'd1;
  localparam logic [1:0] CODE_MINUS = 2'd2;

  // per-cycle control broadcast along the cell row
  typedef struct packed {
    logic h_shift;  // rotate or load public coefficients one place
    logic h_ext;    // first cell takes the external feed instead of the ring
    logic e_clr;    // clear all accumulators
    logic e_shift;  // shift accumulators toward the last cell
    logic add;      // accumulate plus held coefficient
    logic sub;      // accumulate minus held coefficient
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/tcpm_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcpm_cell (
  input  wire logic                     clk,
  input  wire tcpm_pkg::cell_ctrl_t     ctrl,
  input  wire logic [tcpm_pkg::DW-1:0]  h_in,
  input  wire logic [tcpm_pkg::DW-1:0]  e_in,
  output logic      [tcpm_pkg::DW-1:0]  h,
  output logic      [tcpm_pkg::DW-1:0]  e
);

  // public coefficient held by this cell, moves one place per shift
  always_ff @(posedge clk) begin
    if (ctrl.h_shift) begin
      h <= h_in;
    end
  end

  // accumulator: clear, drain, or add/subtract the held coefficient mod 2^16
  always_ff @(posedge clk) begin
    if (ctrl.e_clr) begin
      e <= '0;
    end else if (ctrl.e_shift) begin
      e <= e_in;
    end else if (ctrl.add) begin
      e <= e + h;
    end else if (ctrl.sub) begin
      e <= e - h;
    end
  end

endmodule

`default_nettype wire

// ----- design/tcpm_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcpm_chain (
  input  wire logic                     clk,
  input  wire tcpm_pkg::cell_ctrl_t     ctrl,
  input  wire logic [tcpm_pkg::DW-1:0]  h_feed,
  output logic      [tcpm_pkg::DW-1:0]  e_last
);

  logic [tcpm_pkg::DW-1:0] h_v [tcpm_pkg::RING_DEGREE];
  logic [tcpm_pkg::DW-1:0] e_v [tcpm_pkg::RING_DEGREE];

  // row of cells closed into a ring for the public coefficients
  for (genvar k = 0; k < tcpm_pkg::RING_DEGREE; k++) begin : g_cell
    logic [tcpm_pkg::DW-1:0] h_in;
    logic [tcpm_pkg::DW-1:0] e_in;

    if (k == 0) begin : g_head
      assign h_in = ctrl.h_ext ? h_feed : h_v[tcpm_pkg::RING_DEGREE-1];
      assign e_in = '0;
    end else begin : g_body
      assign h_in = h_v[k-1];
      assign e_in = e_v[k-1];
    end

    tcpm_cell u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .h_in (h_in),
      .e_in (e_in),
      .h    (h_v[k]),
      .e    (e_v[k])
    );
  end

  // drain port at the end of the row
  assign e_last = e_v[tcpm_pkg::RING_DEGREE-1];

endmodule

`default_nettype wire

// ----- design/ternary_cyclic_poly_mult_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake            payload
// command   in         start & !busy        func, index, r_coef, h_coef
// result    out        valid (one cycle)    e_coef
//
// load and read items leave busy low; a read result shows the cycle after the item
// a run holds busy while it loads h into the cell row, steps one ternary
// coefficient per cycle through the row, then drains e into the result memory
// the run time is set by the single read port of the r/h memories and the row's drain
// reset is synchronous; e reads as zero until the first run completes, no clearing pass
// results cannot be stalled; valid is high for exactly one cycle per read

module ternary_cyclic_poly_mult_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  func,
  input  wire logic [tcpm_pkg::IDX_W-1:0]  index,
  input  wire logic [1:0]                  r_coef,
  input  wire logic [tcpm_pkg::DW-1:0]     h_coef,
  output logic                             valid,
  output logic      [tcpm_pkg::DW-1:0]     e_coef
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_HLOAD = 3'd1;
  localparam logic [2:0] ST_MULT  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_TAIL  = 3'd4;
  localparam logic [tcpm_pkg::AW-1:0] LAST = tcpm_pkg::AW'(tcpm_pkg::RING_DEGREE - 1);

  logic [2:0]                 state;
  logic [2:0]                 state_next;
  logic [tcpm_pkg::AW-1:0]    cnt;
  logic [tcpm_pkg::AW-1:0]    cnt_next;
  logic                       p_hl;
  logic                       p_mul;
  logic                       p_dr;
  logic [tcpm_pkg::AW-1:0]    dr_addr;
  logic                       computed;
  logic                       out_zero;
  logic [1:0]                 r_q;
  logic [tcpm_pkg::DW-1:0]    h_q;
  logic [tcpm_pkg::DW-1:0]    e_q;
  logic [tcpm_pkg::DW-1:0]    e_last;
  logic [1:0]                 r_mem [tcpm_pkg::RING_DEGREE];
  logic [tcpm_pkg::DW-1:0]    h_mem [tcpm_pkg::RING_DEGREE];
  logic [tcpm_pkg::DW-1:0]    e_mem [tcpm_pkg::RING_DEGREE];
  logic                       accept;
  logic                       in_range;
  logic [tcpm_pkg::AW-1:0]    addr;
  tcpm_pkg::cell_ctrl_t       ctrl;

  // command decode
  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(index) < 32'(tcpm_pkg::RING_DEGREE));
  assign addr     = tcpm_pkg::AW'(index);

  // sequencer next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (accept && func == tcpm_pkg::FUNC_RUN) begin
          state_next = ST_HLOAD;
          cnt_next   = LAST;
        end
      end
      ST_HLOAD: begin
        if (cnt == '0) begin
          state_next = ST_MULT;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_MULT: begin
        if (cnt == LAST) begin
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (cnt == '0) begin
          state_next = ST_TAIL;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_TAIL: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer and pipeline flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      p_hl     <= 1'b0;
      p_mul    <= 1'b0;
      p_dr     <= 1'b0;
      computed <= 1'b0;
      valid    <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      p_hl  <= (state == ST_HLOAD);
      p_mul <= (state == ST_MULT);
      p_dr  <= (state == ST_DRAIN);
      if (state == ST_TAIL) begin
        computed <= 1'b1;
      end
      valid <= accept && (func == tcpm_pkg::FUNC_READ);
    end
  end

  // drain address is a registered copy of the issue counter
  always_ff @(posedge clk) begin
    dr_addr  <= cnt;
    out_zero <= !in_range || !computed;
  end

  // r and h memories: written by load items, read in sequence during a run
  always_ff @(posedge clk) begin
    if (accept && func == tcpm_pkg::FUNC_LOAD && in_range) begin
      r_mem[addr] <= r_coef;
      h_mem[addr] <= h_coef;
    end
    r_q <= r_mem[cnt];
    h_q <= h_mem[cnt];
  end

  // result memory: filled by the drain, read by read items
  always_ff @(posedge clk) begin
    if (p_dr) begin
      e_mem[dr_addr] <= e_last;
    end
    e_q <= e_mem[addr];
  end

  // cell row control
  always_comb begin
    ctrl.h_shift = p_hl || p_mul;
    ctrl.h_ext   = p_hl;
    ctrl.e_clr   = accept && (func == tcpm_pkg::FUNC_RUN);
    ctrl.e_shift = p_dr;
    ctrl.add     = p_mul && (r_q == tcpm_pkg::CODE_PLUS);
    ctrl.sub     = p_mul && (r_q == tcpm_pkg::CODE_MINUS);
  end

  tcpm_chain u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .h_feed (h_q),
    .e_last (e_last)
  );

  assign e_coef = out_zero ? '0 : e_q;

  // checks
  a_valid_after_read: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(start && !busy && func == tcpm_pkg::FUNC_READ))
    else $error("result strobe without a read item");

  a_busy_after_run: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && func == tcpm_pkg::FUNC_RUN))
    else $error("busy rose without a run item");

  a_phase_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({p_hl, p_mul, p_dr}))
    else $error("overlapping run phases");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !(p_hl || p_mul || p_dr))
    else $error("row activity while idle");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) < 32'(tcpm_pkg::RING_DEGREE))
    else $error("sequence counter out of range");

endmodule

`default_nettype wire
